/* hdl/tbsr_pkg.sv */
`timescale 1ns / 1ps
package tbsr_pkg;

    localparam int NUM_SLOTS = 1024;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int NCNT_W    = SLOT_W + 1;
    localparam int TS_W      = 48;
    localparam int BW_W      = 20;
    localparam int SIU_W     = 11;
    localparam int DUR_W     = BW_W + NCNT_W;

    localparam logic [1:0] ST_HIT   = 2'd0;
    localparam logic [1:0] ST_MOVED = 2'd1;
    localparam logic [1:0] ST_DROP  = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_MERGE  = 1'b1;

    localparam logic CFG_BUCKET_WIDTH = 1'b0;
    localparam logic CFG_SLOTS_IN_USE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [47:0]        timestamp;
        logic signed [31:0] sample_value;
        logic [31:0]        in_count;
        logic signed [63:0] in_sum;
        logic [62:0]        in_sum_sqr;
        logic signed [31:0] in_min;
        logic signed [31:0] in_max;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot_index;
        logic [47:0] bucket_start;
    } t_result;

    typedef struct packed {
        logic [47:0]        start;
        logic [31:0]        cnt;
        logic signed [63:0] sum;
        logic [63:0]        sq;
        logic signed [31:0] mn;
        logic signed [31:0] mx;
    } t_entry;

    // control from the sequencer to the merge logic
    typedef struct packed {
        logic        set_start;
        logic [47:0] new_start;
        logic [63:0] sample_sq;
    } t_upd_ctl;

endpackage

/* hdl/tbsr_mem.sv */
`timescale 1ns / 1ps
module tbsr_mem (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [tbsr_pkg::SLOT_W-1:0] i_waddr,
    input  tbsr_pkg::t_entry       i_wdata,
    input  logic                   i_re,
    input  logic [tbsr_pkg::SLOT_W-1:0] i_raddr,
    output tbsr_pkg::t_entry       o_rdata
);
    import tbsr_pkg::*;

    t_entry r_mem [NUM_SLOTS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tbsr_rem.sv */
`timescale 1ns / 1ps
module tbsr_rem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [tbsr_pkg::TS_W-1:0] i_ts,
    input  logic [tbsr_pkg::BW_W-1:0] i_w,
    output logic                      o_done,
    output logic [tbsr_pkg::BW_W-1:0] o_rem
);
    import tbsr_pkg::*;

    localparam int CNT_W = $clog2(TS_W);

    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;
    logic [BW_W-1:0]  r_rem;
    logic [TS_W-1:0]  r_shift;
    logic [BW_W:0]    trial;
    logic [BW_W:0]    n_trial;

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        trial   = {r_rem, r_shift[TS_W-1]};
        n_trial = (trial >= {1'b0, i_w}) ? trial - {1'b0, i_w} : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(TS_W - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem   <= '0;
            r_shift <= i_ts;
        end else if (r_run) begin
            r_rem   <= n_trial[BW_W-1:0];
            r_shift <= {r_shift[TS_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* hdl/tbsr_upd.sv */
`timescale 1ns / 1ps
module tbsr_upd (
    input  tbsr_pkg::t_entry   i_old,
    input  tbsr_pkg::t_item    i_item,
    input  tbsr_pkg::t_upd_ctl i_ctl,
    output tbsr_pkg::t_entry   o_new
);
    import tbsr_pkg::*;

    logic [31:0]        a_cnt;
    logic signed [63:0] a_sum;
    logic [63:0]        a_sq;
    logic signed [31:0] a_mn;
    logic signed [31:0] a_mx;
    logic               a_ext;
    logic [32:0]        cnt_sum;
    logic [64:0]        sq_sum;
    logic [63:0]        s_sum;
    logic               s_ovf;

    always_comb begin
        if (i_item.opcode == OP_SAMPLE) begin
            a_cnt = 32'd1;
            a_sum = 64'(i_item.sample_value);
            a_sq  = i_ctl.sample_sq;
            a_mn  = i_item.sample_value;
            a_mx  = i_item.sample_value;
            a_ext = 1'b1;
        end else begin
            a_cnt = i_item.in_count;
            a_sum = i_item.in_sum;
            a_sq  = {1'b0, i_item.in_sum_sqr};
            a_mn  = i_item.in_min;
            a_mx  = i_item.in_max;
            a_ext = (i_item.in_count != 32'd0);
        end

        cnt_sum = {1'b0, i_old.cnt} + {1'b0, a_cnt};
        sq_sum  = {1'b0, i_old.sq} + {1'b0, a_sq};
        s_sum   = i_old.sum + a_sum;
        s_ovf   = (i_old.sum[63] == a_sum[63]) && (s_sum[63] != a_sum[63]);

        o_new       = i_old;
        o_new.start = i_ctl.set_start ? i_ctl.new_start : i_old.start;
        o_new.cnt   = cnt_sum[32] ? 32'hFFFF_FFFF : cnt_sum[31:0];
        o_new.sq    = sq_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_sum[63:0];
        if (s_ovf) begin
            o_new.sum = a_sum[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end else begin
            o_new.sum = s_sum;
        end
        // an empty bucket takes its extremes from the first contribution
        if (a_ext) begin
            if (i_old.cnt == 32'd0) begin
                o_new.mn = a_mn;
                o_new.mx = a_mx;
            end else begin
                if (a_mn < i_old.mn) o_new.mn = a_mn;
                if (a_mx > i_old.mx) o_new.mx = a_mx;
            end
        end
    end

endmodule

/* hdl/time_bucket_stats_ring.sv */
`timescale 1ns / 1ps
// Time-bucket statistics ring. An item is taken when start is high and busy is
// low; exactly one result follows, shown for one cycle with o_res_vld, and it
// cannot be held off. An item that lands in the current bucket passes through
// setup, decide, memory read and write-back before the strobe. A forward move
// clears and restamps each bucket advanced through the memory write port, a
// step back walks one bucket at a time without touching the memory. A gap of
// a full window wipes the whole memory and realigns to the timestamp's bucket.
// After reset the block clears the whole memory with busy high; configuration
// writes are taken at any time.
module time_bucket_stats_ring (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  tbsr_pkg::t_item            i_item,
    output logic                       o_res_vld,
    output tbsr_pkg::t_result          o_result,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [tbsr_pkg::BW_W-1:0]  i_cfg_data
);
    import tbsr_pkg::*;

    typedef enum logic [9:0] {
        S_INIT  = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_CALC  = 10'b00_0000_0100,
        S_DEC   = 10'b00_0000_1000,
        S_FWD   = 10'b00_0001_0000,
        S_BACK  = 10'b00_0010_0000,
        S_WIPE  = 10'b00_0100_0000,
        S_ALIGN = 10'b00_1000_0000,
        S_RD    = 10'b01_0000_0000,
        S_WR    = 10'b10_0000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [BW_W-1:0]    r_bw;
    logic [SIU_W-1:0]   r_siu;
    logic [SLOT_W-1:0]  r_cur;
    logic [TS_W-1:0]    r_cs;
    logic [SLOT_W-1:0]  r_ptr;
    t_item              r_item;
    logic [BW_W-1:0]    r_w;
    logic [NCNT_W-1:0]  r_n;
    logic [DUR_W-1:0]   r_dur;
    logic [63:0]        r_sq;
    logic [SLOT_W-1:0]  r_tgt;
    logic               r_set_start;
    logic [TS_W-1:0]    r_tgt_start;
    logic [1:0]         r_status;
    logic [TS_W-1:0]    r_t;
    logic [NCNT_W-1:0]  r_k;
    logic               r_out_vld;
    t_result            r_out;

    logic [NCNT_W-1:0]  n_eff;
    logic [BW_W-1:0]    w_eff;
    logic [31:0]        mag;
    logic [TS_W-1:0]    ts;
    logic [TS_W:0]      win_end;
    logic [TS_W-1:0]    fwd_start;
    logic [SLOT_W-1:0]  fwd_slot;
    logic               fwd_last;
    logic [TS_W-1:0]    back_t;
    logic [SLOT_W-1:0]  back_slot;
    logic [NCNT_W-1:0]  back_k;
    logic               back_drop;
    logic               accept;
    logic               rem_go;
    logic               rem_done;
    logic [BW_W-1:0]    rem;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    t_entry             mem_wdata;
    t_entry             mem_rdata;
    t_entry             upd_entry;
    t_upd_ctl           upd_ctl;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign ts     = r_item.timestamp;

    always_comb begin
        if (r_siu == '0) begin
            n_eff = NCNT_W'(1);
        end else if (r_siu > SIU_W'(NUM_SLOTS)) begin
            n_eff = NCNT_W'(NUM_SLOTS);
        end else begin
            n_eff = NCNT_W'(r_siu);
        end
        w_eff = (r_bw == '0) ? BW_W'(1) : r_bw;
        mag   = r_item.sample_value[31] ? (~r_item.sample_value + 32'd1)
                                        : r_item.sample_value;

        win_end = {1'b0, r_cs} + (TS_W+1)'(r_dur);

        fwd_start = r_cs + TS_W'(r_w);
        fwd_slot  = ((NCNT_W'(r_cur) + 1'b1) >= r_n) ? '0 : r_cur + 1'b1;
        fwd_last  = (ts - fwd_start) < TS_W'(r_w);

        back_t    = r_t - TS_W'(r_w);
        back_k    = r_k + 1'b1;
        back_slot = (r_tgt == '0) ? SLOT_W'(r_n - 1'b1) : r_tgt - 1'b1;
        back_drop = (back_k >= r_n) || (TS_W'(r_w) > r_t);
    end

    always_comb begin
        n_state = r_state;
        rem_go  = 1'b0;
        case (r_state)
            S_INIT:  if (r_ptr == SLOT_W'(NUM_SLOTS - 1)) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_CALC;
            S_CALC:  n_state = S_DEC;
            S_DEC: begin
                if (win_end <= {1'b0, ts}) begin
                    n_state = S_WIPE;
                    rem_go  = 1'b1;
                end else if (r_cs <= ts) begin
                    n_state = ((ts - r_cs) >= TS_W'(r_w)) ? S_FWD : S_RD;
                end else begin
                    n_state = S_BACK;
                end
            end
            S_FWD:   if (fwd_last) n_state = S_RD;
            S_BACK: begin
                if (back_drop) begin
                    n_state = S_IDLE;
                end else if (back_t <= ts) begin
                    n_state = S_RD;
                end
            end
            S_WIPE:  if (r_ptr == SLOT_W'(NUM_SLOTS - 1)) n_state = S_ALIGN;
            S_ALIGN: if (rem_done) n_state = S_RD;
            S_RD:    n_state = S_WR;
            S_WR:    n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_bw      <= BW_W'(60);
            r_siu     <= SIU_W'(NUM_SLOTS);
            r_cur     <= '0;
            r_cs      <= '0;
            r_ptr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= (r_state == S_WR) || ((r_state == S_BACK) && back_drop);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BUCKET_WIDTH: r_bw  <= i_cfg_data;
                    CFG_SLOTS_IN_USE: r_siu <= i_cfg_data[SIU_W-1:0];
                    default:          r_bw  <= r_bw;
                endcase
            end
            case (r_state)
                S_INIT, S_WIPE: r_ptr <= r_ptr + 1'b1;
                S_CALC: begin
                    if (NCNT_W'(r_cur) >= n_eff) r_cur <= SLOT_W'(n_eff - 1'b1);
                end
                S_DEC:   r_ptr <= '0;
                S_FWD: begin
                    r_cur <= fwd_slot;
                    r_cs  <= fwd_start;
                end
                S_ALIGN: begin
                    if (rem_done) begin
                        r_cur <= '0;
                        r_cs  <= ts - TS_W'(rem);
                    end
                end
                default: r_ptr <= r_ptr;
            endcase
        end
    end

    // transaction payload and walk registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (accept) r_item <= i_item;
            S_CALC: begin
                r_w   <= w_eff;
                r_n   <= n_eff;
                r_dur <= DUR_W'(w_eff) * DUR_W'(n_eff);
                r_sq  <= 64'(mag) * 64'(mag);
            end
            S_DEC: begin
                r_tgt       <= r_cur;
                r_t         <= r_cs;
                r_k         <= '0;
                r_set_start <= 1'b0;
                r_status    <= (r_cs > ts || (ts - r_cs) >= TS_W'(r_w)) ? ST_MOVED
                                                                         : ST_HIT;
            end
            S_FWD:  r_tgt <= fwd_slot;
            S_BACK: begin
                r_t         <= back_t;
                r_k         <= back_k;
                r_tgt       <= back_slot;
                r_set_start <= 1'b1;
                r_tgt_start <= back_t;
                if (back_drop) begin
                    r_out.status       <= ST_DROP;
                    r_out.slot_index   <= '0;
                    r_out.bucket_start <= '0;
                end
            end
            S_ALIGN: begin
                r_tgt       <= '0;
                r_set_start <= 1'b1;
                r_tgt_start <= ts - TS_W'(rem);
            end
            S_WR: begin
                r_out.status       <= r_status;
                r_out.slot_index   <= 10'(r_tgt);
                r_out.bucket_start <= upd_entry.start;
            end
            default: r_t <= r_t;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = '0;
        case (r_state)
            S_INIT, S_WIPE: mem_we = 1'b1;
            S_FWD: begin
                mem_we          = 1'b1;
                mem_waddr       = fwd_slot;
                mem_wdata.start = fwd_start;
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_tgt;
                mem_wdata = upd_entry;
            end
            default: mem_we = 1'b0;
        endcase
        upd_ctl.set_start = r_set_start;
        upd_ctl.new_start = r_tgt_start;
        upd_ctl.sample_sq = r_sq;
    end

    tbsr_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (r_state == S_RD),
        .i_raddr (r_tgt),
        .o_rdata (mem_rdata)
    );

    tbsr_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (rem_go),
        .i_ts    (ts),
        .i_w     (r_w),
        .o_done  (rem_done),
        .o_rem   (rem)
    );

    tbsr_upd u_upd (
        .i_old  (mem_rdata),
        .i_item (r_item),
        .i_ctl  (upd_ctl),
        .o_new  (upd_entry)
    );

    assign o_res_vld = r_out_vld;
    assign o_result  = r_out;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy) else $error("accepted transaction did not raise busy");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> !busy) else $error("result strobe while still working");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && o_result.status == ST_DROP) |->
        (o_result.slot_index == '0 && o_result.bucket_start == '0))
        else $error("dropped transaction reports a bucket");

    a_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_WR)) else $error("read not followed by write-back");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import tbsr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4 * NUM_SLOTS * 1024 + 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_res_vld;
    t_result     o_result;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [BW_W-1:0] i_cfg_data;

    time_bucket_stats_ring i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_res_vld  (o_res_vld),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the ring
    logic [47:0]        shadow_start [NUM_SLOTS];
    logic [31:0]        shadow_cnt   [NUM_SLOTS];
    logic signed [63:0] shadow_sum   [NUM_SLOTS];
    logic [63:0]        shadow_sq    [NUM_SLOTS];
    logic signed [31:0] shadow_mn    [NUM_SLOTS];
    logic signed [31:0] shadow_mx    [NUM_SLOTS];
    int unsigned        shadow_slot;
    logic [47:0]        shadow_cur_start;
    logic [19:0]        width_reg;
    logic [10:0]        slots_reg;

    t_result     pending_results [$];
    int          mismatch_count;
    int          idle_cycles;
    bit          idle_enabled;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_shadow_slot(int unsigned s);
        shadow_start[s] = '0;
        shadow_cnt[s]   = '0;
        shadow_sum[s]   = '0;
        shadow_sq[s]    = '0;
        shadow_mn[s]    = '0;
        shadow_mx[s]    = '0;
    endfunction

    function automatic void merge_into_slot(int unsigned s, logic [31:0] cnt,
                                            logic signed [63:0] sum, logic [63:0] sq,
                                            logic signed [31:0] mn,
                                            logic signed [31:0] mx, bit take_ext);
        logic [32:0]        cnt_sum;
        logic signed [63:0] sum_r;
        logic [64:0]        sq_sum;
        if (take_ext) begin
            if (shadow_cnt[s] == 0) begin
                shadow_mn[s] = mn;
                shadow_mx[s] = mx;
            end else begin
                if (mn < shadow_mn[s]) shadow_mn[s] = mn;
                if (mx > shadow_mx[s]) shadow_mx[s] = mx;
            end
        end
        cnt_sum = {1'b0, shadow_cnt[s]} + {1'b0, cnt};
        shadow_cnt[s] = cnt_sum[32] ? 32'hFFFF_FFFF : cnt_sum[31:0];
        sum_r = shadow_sum[s] + sum;
        if (shadow_sum[s][63] == sum[63] && sum_r[63] != sum[63])
            sum_r = sum[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        shadow_sum[s] = sum_r;
        sq_sum = {1'b0, shadow_sq[s]} + {1'b0, sq};
        shadow_sq[s] = sq_sum[64] ? '1 : sq_sum[63:0];
    endfunction

    function automatic t_result predict_bucket(t_item it);
        logic [63:0] w, dur, ts, k, slot_sel, mag;
        int unsigned n;
        logic [1:0]  status;
        t_result     r;
        w  = (width_reg == 0) ? 64'd1 : 64'(width_reg);
        n  = (slots_reg == 0) ? 1 : ((slots_reg > NUM_SLOTS) ? NUM_SLOTS : slots_reg);
        ts = 64'(it.timestamp);
        if (shadow_slot >= n) shadow_slot = n - 1;
        dur = w * 64'(n);
        if (64'(shadow_cur_start) + dur <= ts) begin
            for (int i = 0; i < NUM_SLOTS; i++) clear_shadow_slot(i);
            shadow_slot = 0;
            shadow_cur_start = 48'(ts - (ts % w));
            shadow_start[0] = shadow_cur_start;
            slot_sel = 0;
            status = ST_MOVED;
        end else if (64'(shadow_cur_start) <= ts) begin
            k = (ts - 64'(shadow_cur_start)) / w;
            status = (k == 0) ? ST_HIT : ST_MOVED;
            for (longint unsigned i = 0; i < k; i++) begin
                shadow_slot = (shadow_slot + 1 >= n) ? 0 : shadow_slot + 1;
                clear_shadow_slot(shadow_slot);
                shadow_cur_start = shadow_cur_start + 48'(w);
                shadow_start[shadow_slot] = shadow_cur_start;
            end
            slot_sel = shadow_slot;
        end else begin
            k = (64'(shadow_cur_start) - ts + w - 1) / w;
            if (k > 64'(n - 1) || k * w > 64'(shadow_cur_start)) begin
                r.status = ST_DROP;
                r.slot_index = '0;
                r.bucket_start = '0;
                return r;
            end
            slot_sel = (64'(shadow_slot) + 64'(n) - k) % 64'(n);
            shadow_start[slot_sel] = 48'(64'(shadow_cur_start) - k * w);
            status = ST_MOVED;
        end
        if (it.opcode == OP_SAMPLE) begin
            mag = it.sample_value[31] ? 64'(-64'(it.sample_value)) : 64'(it.sample_value);
            merge_into_slot(slot_sel, 32'd1, 64'(it.sample_value), mag * mag,
                            it.sample_value, it.sample_value, 1'b1);
        end else begin
            merge_into_slot(slot_sel, it.in_count, it.in_sum, {1'b0, it.in_sum_sqr},
                            it.in_min, it.in_max, it.in_count != 0);
        end
        r.status = status;
        r.slot_index = slot_sel[9:0];
        r.bucket_start = shadow_start[slot_sel];
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_res_vld) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %p", o_result);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_result.status !== exp_r.status ||
                    o_result.slot_index !== exp_r.slot_index ||
                    o_result.bucket_start !== exp_r.bucket_start) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p got %p", exp_r, o_result);
                end
            end
        end
    end

    // watchdog on stalled traffic
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_vld) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // start stays high after the accepting edge; busy keeps the block from taking it again
    task automatic send_item(t_item it);
        int gap;
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_bucket(it));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [19:0] val);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BUCKET_WIDTH) width_reg = val;
        else slots_reg = 11'(val);
    endtask

    function automatic t_item rand_item(logic [47:0] ts, bit wild);
        t_item it;
        it.opcode       = 1'($urandom_range(0, 1));
        it.timestamp    = ts;
        it.sample_value = $urandom;
        it.in_count     = wild ? $urandom : $urandom_range(0, 20);
        it.in_sum       = {$urandom, $urandom};
        it.in_sum_sqr   = 63'({$urandom, $urandom});
        if (!wild) begin
            it.in_sum     = 64'(signed'(it.sample_value)) * 4;
            it.in_sum_sqr = 63'($urandom);
        end
        it.in_min = $urandom;
        it.in_max = $urandom;
        return it;
    endfunction

    task automatic test_directed();
        t_item it;
        it = rand_item(48'd10, 0);
        it.opcode = OP_SAMPLE;
        it.sample_value = 32'sh7FFF_FFFF;
        send_item(it);
        it.sample_value = 32'sh8000_0000;
        send_item(it);
        it.timestamp = 48'd130;
        send_item(it);
        it.timestamp = 48'd65;
        it.opcode = OP_MERGE;
        it.in_count = 32'hFFFF_FFFF;
        it.in_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
        it.in_sum_sqr = '1;
        send_item(it);
        send_item(it);
        it.in_sum = 64'sh8000_0000_0000_0000;
        send_item(it);
        it.in_count = 0;
        send_item(it);
        it.timestamp = 48'd5;
        send_item(it);
        it.timestamp = '1;
        send_item(it);
        it.timestamp = 48'd3;
        send_item(it);
        it.timestamp = 48'hFFFF_FFFF_FFF0;
        it.opcode = OP_SAMPLE;
        send_item(it);
        drain_results();
    endtask

    task automatic test_configs();
        write_reg(CFG_BUCKET_WIDTH, 20'd0);
        write_reg(CFG_SLOTS_IN_USE, 20'd0);
        send_item(rand_item(48'd100, 0));
        send_item(rand_item(48'd101, 0));
        send_item(rand_item(48'd99, 0));
        write_reg(CFG_SLOTS_IN_USE, 20'd2047);
        send_item(rand_item(48'd101, 0));
        write_reg(CFG_BUCKET_WIDTH, 20'hFFFFF);
        write_reg(CFG_SLOTS_IN_USE, 20'd4);
        send_item(rand_item(48'd200, 1));
        send_item(rand_item(48'd1100000, 1));
        send_item(rand_item(48'd300, 1));
        drain_results();
    endtask

    task automatic run_random_phase(int count, logic [19:0] w, logic [10:0] n);
        logic [63:0] ts, span;
        int pick;
        write_reg(CFG_BUCKET_WIDTH, w);
        write_reg(CFG_SLOTS_IN_USE, 20'(n));
        span = 64'(w == 0 ? 1 : w) * 64'(n == 0 ? 1 : n);
        ts = 64'(shadow_cur_start);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) ts = 64'(shadow_cur_start) + $urandom_range(0, w);
            else if (pick < 75) ts = 64'(shadow_cur_start) + $urandom_range(0, 3 * w);
            else if (pick < 88) ts = 64'(shadow_cur_start) - 64'($urandom_range(0, 32'(span)));
            else if (pick < 95) ts = 64'(shadow_cur_start) + span + $urandom_range(0, 1000);
            else ts = {$urandom, $urandom};
            send_item(rand_item(48'(ts), $urandom_range(0, 9) == 0));
        end
        drain_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_BUCKET_WIDTH;
        i_cfg_data = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        idle_enabled = 1'b1;
        width_reg = 20'd60;
        slots_reg = 11'd1024;
        shadow_slot = 0;
        shadow_cur_start = '0;
        for (int i = 0; i < NUM_SLOTS; i++) clear_shadow_slot(i);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_configs();
        run_random_phase(400, 20'd60, 11'd16);
        run_random_phase(300, 20'd1, 11'd1);
        run_random_phase(300, 20'd7, 11'd1024);
        idle_enabled = 1'b0;
        run_random_phase(400, 20'd1000000, 11'd3);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
